>>> rtl/core/bfm_pkg.sv
// Shared types and constants of the Brainfuck machine.
package bfm_pkg;

    // Defaults for the top-level parameters
    localparam int PROGRAM_DEPTH_DEF = 4096;
    localparam int TAPE_DEPTH_DEF    = 32768;
    localparam int NEST_DEPTH_DEF    = 64;

    // Field widths fixed by the interface
    localparam int LOAD_ADDR_W = 12;
    localparam int BYTE_W      = 8;
    localparam int SKIP_W      = 13;
    localparam logic [SKIP_W-1:0] SKIP_MAX = '1;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // Item modes as carried on tuser
    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_STEP  = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_RUNNING  = 2'd0;
    localparam logic [1:0] ST_WAIT_IN  = 2'd1;
    localparam logic [1:0] ST_HALT_END = 2'd2;
    localparam logic [1:0] ST_HALT_OVF = 2'd3;

    // Program characters
    localparam logic [7:0] CH_RIGHT = 8'h3E;
    localparam logic [7:0] CH_LEFT  = 8'h3C;
    localparam logic [7:0] CH_INC   = 8'h2B;
    localparam logic [7:0] CH_DEC   = 8'h2D;
    localparam logic [7:0] CH_OUT   = 8'h2E;
    localparam logic [7:0] CH_IN    = 8'h2C;
    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_CLOSE = 8'h5D;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_START = 2'd1,
        KIND_STEP  = 2'd2,
        KIND_NOP   = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t                  kind;
        logic                   load_ok;
        logic [LOAD_ADDR_W-1:0] load_address;
        logic [BYTE_W-1:0]      program_byte;
        logic                   input_offered;
        logic [BYTE_W-1:0]      input_byte;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } q_if_t;

    typedef struct packed {
        logic              output_valid;
        logic [BYTE_W-1:0] output_byte;
        logic [1:0]        status;
    } res_t;

endpackage

>>> rtl/core/bfm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module bfm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/bfm_front.sv
// Front end: accepts input beats, classifies them and queues them for the back end.
module bfm_front #(
    parameter int PROGRAM_DEPTH = bfm_pkg::PROGRAM_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [31:0]        s_axis_tdata,
    input  logic [1:0]         s_axis_tuser,
    input  logic               clearing,
    input  logic               q_pop,
    output bfm_pkg::q_if_t     q
);

    bfm_pkg::entry_t fifo_reg [bfm_pkg::QUEUE_DEPTH];
    logic [bfm_pkg::QUEUE_AW-1:0] wptr_reg, wptr_next;
    logic [bfm_pkg::QUEUE_AW-1:0] rptr_reg, rptr_next;
    logic [bfm_pkg::QUEUE_AW:0]   count_reg, count_next;
    bfm_pkg::entry_t in_entry;
    logic push;

    always_comb
    begin
        in_entry.load_address  = s_axis_tdata[11:0];
        in_entry.program_byte  = s_axis_tdata[19:12];
        in_entry.input_offered = s_axis_tdata[20];
        in_entry.input_byte    = s_axis_tdata[28:21];
        in_entry.load_ok       = ({20'd0, s_axis_tdata[11:0]} < 32'(PROGRAM_DEPTH));
        case (s_axis_tuser)
            bfm_pkg::MODE_LOAD:  in_entry.kind = bfm_pkg::KIND_LOAD;
            bfm_pkg::MODE_START: in_entry.kind = bfm_pkg::KIND_START;
            bfm_pkg::MODE_STEP:  in_entry.kind = bfm_pkg::KIND_STEP;
            default:             in_entry.kind = bfm_pkg::KIND_NOP;
        endcase
    end

    // no new beats while the tape is being wiped
    assign s_axis_tready = (count_reg != (bfm_pkg::QUEUE_AW+1)'(bfm_pkg::QUEUE_DEPTH))
                           && !clearing;
    assign push = s_axis_tvalid && s_axis_tready;

    assign q.valid = (count_reg != '0);
    assign q.entry = fifo_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wptr_next = wptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rptr_next = rptr_reg + 1'b1;
        end
        case ({push, q_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wptr_reg] <= in_entry;
        end
    end

endmodule

>>> rtl/core/bfm_back.sv
// Back end: runs queued items against the program store, tape and bracket stack.
module bfm_back #(
    parameter int PROGRAM_DEPTH = bfm_pkg::PROGRAM_DEPTH_DEF,
    parameter int TAPE_DEPTH    = bfm_pkg::TAPE_DEPTH_DEF,
    parameter int NEST_DEPTH    = bfm_pkg::NEST_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  bfm_pkg::q_if_t q,
    output logic           q_pop,
    input  logic           res_ready,
    output logic           res_valid,
    output bfm_pkg::res_t  res,
    output logic           clearing
);

    localparam int PC_W = $clog2(PROGRAM_DEPTH + 1);
    localparam int PA_W = $clog2(PROGRAM_DEPTH);
    localparam int DP_W = $clog2(TAPE_DEPTH);
    localparam int LV_W = $clog2(NEST_DEPTH + 1);
    localparam int SA_W = $clog2(NEST_DEPTH);

    typedef enum logic [2:0] {
        B_IDLE  = 3'b001,
        B_EXEC  = 3'b010,
        B_CLEAR = 3'b100
    } bstate_t;

    bstate_t state_reg, state_next;
    logic [PC_W-1:0]            pc_reg, pc_next;
    logic [DP_W-1:0]            dp_reg, dp_next;
    logic [LV_W-1:0]            level_reg, level_next;
    logic [bfm_pkg::SKIP_W-1:0] skip_reg, skip_next;
    logic                       halted_reg, halted_next;
    logic                       ovf_reg, ovf_next;
    logic [DP_W-1:0]            clr_reg, clr_next;
    bfm_pkg::entry_t            cur_reg, cur_next;

    logic                       prog_we;
    logic [7:0]                 prog_rdata;
    logic                       tape_we;
    logic [DP_W-1:0]            tape_waddr;
    logic [7:0]                 tape_wdata;
    logic [7:0]                 tape_rdata;
    logic                       exec_tape_we;
    logic [7:0]                 exec_tape_wdata;
    logic                       stack_we;
    logic [PA_W-1:0]            stack_rdata;
    logic [1:0]                 idle_status;

    assign idle_status = !halted_reg ? bfm_pkg::ST_RUNNING
                       : (ovf_reg ? bfm_pkg::ST_HALT_OVF : bfm_pkg::ST_HALT_END);
    assign clearing = (state_reg == B_CLEAR);

    bfm_ram #(.WIDTH(8), .DEPTH(PROGRAM_DEPTH)) u_prog (
        .clk   (clk),
        .we    (prog_we),
        .waddr (PA_W'(q.entry.load_address)),
        .wdata (q.entry.program_byte),
        .raddr (pc_reg[PA_W-1:0]),
        .rdata (prog_rdata)
    );

    assign tape_we    = clearing || exec_tape_we;
    assign tape_waddr = clearing ? clr_reg : dp_reg;
    assign tape_wdata = clearing ? 8'd0 : exec_tape_wdata;

    bfm_ram #(.WIDTH(8), .DEPTH(TAPE_DEPTH)) u_tape (
        .clk   (clk),
        .we    (tape_we),
        .waddr (tape_waddr),
        .wdata (tape_wdata),
        .raddr (dp_reg),
        .rdata (tape_rdata)
    );

    // top of stack is read at level-1; unused while the stack is empty
    bfm_ram #(.WIDTH(PA_W), .DEPTH(NEST_DEPTH)) u_stack (
        .clk   (clk),
        .we    (stack_we),
        .waddr (level_reg[SA_W-1:0]),
        .wdata (pc_reg[PA_W-1:0]),
        .raddr (SA_W'(level_reg - 1'b1)),
        .rdata (stack_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        pc_next         = pc_reg;
        dp_next         = dp_reg;
        level_next      = level_reg;
        skip_next       = skip_reg;
        halted_next     = halted_reg;
        ovf_next        = ovf_reg;
        clr_next        = clr_reg;
        cur_next        = cur_reg;
        q_pop           = 1'b0;
        prog_we         = 1'b0;
        exec_tape_we    = 1'b0;
        exec_tape_wdata = tape_rdata;
        stack_we        = 1'b0;
        res_valid       = 1'b0;
        res.output_valid = 1'b0;
        res.output_byte  = 8'd0;
        res.status       = idle_status;

        case (state_reg)
            B_IDLE:
            begin
                if (q.valid && res_ready)
                begin
                    q_pop = 1'b1;
                    case (q.entry.kind)
                        bfm_pkg::KIND_LOAD:
                        begin
                            prog_we   = q.entry.load_ok;
                            res_valid = 1'b1;
                        end
                        bfm_pkg::KIND_START:
                        begin
                            pc_next     = '0;
                            dp_next     = '0;
                            level_next  = '0;
                            skip_next   = '0;
                            halted_next = 1'b0;
                            ovf_next    = 1'b0;
                            clr_next    = '0;
                            state_next  = B_CLEAR;
                            res_valid   = 1'b1;
                            res.status  = bfm_pkg::ST_RUNNING;
                        end
                        bfm_pkg::KIND_STEP:
                        begin
                            if (halted_reg)
                            begin
                                res_valid = 1'b1;
                            end
                            else if (pc_reg >= PC_W'(PROGRAM_DEPTH))
                            begin
                                halted_next = 1'b1;
                                res_valid   = 1'b1;
                                res.status  = bfm_pkg::ST_HALT_END;
                            end
                            else
                            begin
                                cur_next   = q.entry;
                                state_next = B_EXEC;
                            end
                        end
                        default:
                        begin
                            res_valid = 1'b1;
                        end
                    endcase
                end
            end

            B_EXEC:
            begin
                if (res_ready)
                begin
                    res_valid  = 1'b1;
                    res.status = bfm_pkg::ST_RUNNING;
                    state_next = B_IDLE;
                    if (prog_rdata == 8'd0)
                    begin
                        halted_next = 1'b1;
                        res.status  = bfm_pkg::ST_HALT_END;
                    end
                    else if (skip_reg != '0)
                    begin
                        // skipping a loop body: only brackets count
                        if (prog_rdata == bfm_pkg::CH_OPEN)
                        begin
                            if (skip_reg != bfm_pkg::SKIP_MAX)
                            begin
                                skip_next = skip_reg + 1'b1;
                            end
                        end
                        else if (prog_rdata == bfm_pkg::CH_CLOSE)
                        begin
                            skip_next = skip_reg - 1'b1;
                        end
                        pc_next = pc_reg + 1'b1;
                    end
                    else
                    begin
                        pc_next = pc_reg + 1'b1;
                        case (prog_rdata)
                            bfm_pkg::CH_RIGHT:
                            begin
                                dp_next = (dp_reg == DP_W'(TAPE_DEPTH - 1)) ? '0
                                          : dp_reg + 1'b1;
                            end
                            bfm_pkg::CH_LEFT:
                            begin
                                dp_next = (dp_reg == '0) ? DP_W'(TAPE_DEPTH - 1)
                                          : dp_reg - 1'b1;
                            end
                            bfm_pkg::CH_INC:
                            begin
                                exec_tape_we    = 1'b1;
                                exec_tape_wdata = tape_rdata + 8'd1;
                            end
                            bfm_pkg::CH_DEC:
                            begin
                                exec_tape_we    = 1'b1;
                                exec_tape_wdata = tape_rdata - 8'd1;
                            end
                            bfm_pkg::CH_OUT:
                            begin
                                res.output_valid = 1'b1;
                                res.output_byte  = tape_rdata;
                            end
                            bfm_pkg::CH_IN:
                            begin
                                if (!cur_reg.input_offered || cur_reg.input_byte == 8'd0)
                                begin
                                    res.status = bfm_pkg::ST_WAIT_IN;
                                    pc_next    = pc_reg;
                                end
                                else
                                begin
                                    exec_tape_we    = 1'b1;
                                    exec_tape_wdata = cur_reg.input_byte;
                                end
                            end
                            bfm_pkg::CH_OPEN:
                            begin
                                if (tape_rdata == 8'd0)
                                begin
                                    skip_next = bfm_pkg::SKIP_W'(1);
                                end
                                else if (level_reg >= LV_W'(NEST_DEPTH))
                                begin
                                    halted_next = 1'b1;
                                    ovf_next    = 1'b1;
                                    res.status  = bfm_pkg::ST_HALT_OVF;
                                    pc_next     = pc_reg;
                                end
                                else
                                begin
                                    stack_we   = 1'b1;
                                    level_next = level_reg + 1'b1;
                                end
                            end
                            bfm_pkg::CH_CLOSE:
                            begin
                                if (level_reg != '0)
                                begin
                                    if (tape_rdata != 8'd0)
                                    begin
                                        pc_next = PC_W'(stack_rdata) + 1'b1;
                                    end
                                    else
                                    begin
                                        level_next = level_reg - 1'b1;
                                    end
                                end
                            end
                            default:
                            begin
                                pc_next = pc_reg + 1'b1;
                            end
                        endcase
                    end
                end
            end

            B_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == DP_W'(TAPE_DEPTH - 1))
                begin
                    state_next = B_IDLE;
                end
            end

            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_CLEAR;
            pc_reg     <= '0;
            dp_reg     <= '0;
            level_reg  <= '0;
            skip_reg   <= '0;
            halted_reg <= 1'b1;
            ovf_reg    <= 1'b0;
            clr_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            pc_reg     <= pc_next;
            dp_reg     <= dp_next;
            level_reg  <= level_next;
            skip_reg   <= skip_next;
            halted_reg <= halted_next;
            ovf_reg    <= ovf_next;
            clr_reg    <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

endmodule

>>> rtl/core/brainfuck_machine_step.sv
// Top level of the Brainfuck machine: front end, back end and result register.
//
// One input stream (s_axis) carries items, one result stream (m_axis) returns
// exactly one result beat per input beat, in order. tuser on the input is the
// mode: load a program byte, start a run, or execute one program character.
// Loads, starts and no-op modes are finished in the back end's idle state; a
// step on a running machine also passes the execute state: the program store,
// tape and bracket stack memories are read (registered reads), then it decodes,
// writes the cell back and forms the result. Items reach the back end through
// the four-entry queue and results leave through the output register; the back
// end takes no new item while a step is in its execute state.
// After reset and after every start item the tape is wiped one cell a cycle;
// s_axis_tready stays low while it runs. The machine comes out of reset halted.
// When m_axis_tready is low the result register holds, the back end waits, the
// queue fills and then s_axis_tready drops.
module brainfuck_machine_step #(
    parameter int PROGRAM_DEPTH = bfm_pkg::PROGRAM_DEPTH_DEF,
    parameter int TAPE_DEPTH    = bfm_pkg::TAPE_DEPTH_DEF,
    parameter int NEST_DEPTH    = bfm_pkg::NEST_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [11:0] load_address, [19:12] program_byte, [20] input_offered,
    // [28:21] input_byte, [31:29] zero
    input  logic [31:0] s_axis_tdata,
    // [1:0] mode
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] output_byte
    output logic [7:0]  m_axis_tdata,
    // [0] output_valid, [2:1] status
    output logic [2:0]  m_axis_tuser
);

    bfm_pkg::q_if_t q;
    logic           q_pop;
    logic           clearing;
    logic           res_valid;
    logic           res_ready;
    bfm_pkg::res_t  res;
    logic           out_valid_reg, out_valid_next;
    bfm_pkg::res_t  out_reg;

    bfm_front #(.PROGRAM_DEPTH(PROGRAM_DEPTH)) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .clearing      (clearing),
        .q_pop         (q_pop),
        .q             (q)
    );

    bfm_back #(
        .PROGRAM_DEPTH (PROGRAM_DEPTH),
        .TAPE_DEPTH    (TAPE_DEPTH),
        .NEST_DEPTH    (NEST_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q         (q),
        .q_pop     (q_pop),
        .res_ready (res_ready),
        .res_valid (res_valid),
        .res       (res),
        .clearing  (clearing)
    );

    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg.output_byte;
    assign m_axis_tuser  = {out_reg.status, out_reg.output_valid};

    // back end only hands over a result when the output slot is free
    a_res_slot: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (!out_valid_reg || m_axis_tready))
        else $error("result produced with output register occupied");

    // a printed byte only comes with a running status
    a_print_running: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tuser[2:1] == bfm_pkg::ST_RUNNING))
        else $error("print beat with non-running status");

    // a beat that prints nothing carries a zero byte
    a_quiet_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == 8'd0))
        else $error("non-print beat with nonzero byte");

    // no input accepted during the tape wipe
    a_clear_block: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !(s_axis_tvalid && s_axis_tready))
        else $error("input beat accepted during tape wipe");

endmodule
